// ===== hdl/bmp_pkg.sv =====
// bmp_pkg: shared types and codes for the 24-bit raster to rgb565 writer
// no dependencies; used by every module of the block by scoped names

package bmp_pkg;

   // result kinds
   localparam logic KIND_CURSOR = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_UP    = 3'd4;

   // configuration register file contents
   typedef struct packed {
      logic [9:0]  origin_x;
      logic [9:0]  origin_y;
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic        bottom_up;
   } cfg_type;

   // one classified pixel: its color and the cursors around it
   typedef struct packed {
      logic [15:0] color;
      logic [9:0]  cursor_x;
      logic        has_start;
      logic [10:0] start_y;
      logic        has_next;
      logic [10:0] next_y;
   } job_type;

endpackage

// ===== hdl/bmp24_to_rgb565_raster.sv =====
// bmp24_to_rgb565_raster: top level of the 24-bit raster to rgb565 writer
// depends on bmp_pkg, bmp_front, bmp_queue and bmp_back
//
// channel | ports             | direction | transfer moves
// req     | req_valid/ready   | in        | one raw pixel byte
// rsp     | rsp_valid/ready   | out       | one cursor command or pixel write
// csr     | csr_valid/ready   | in        | one register index and write data
//
// one byte is taken per cycle while req_ready is high; every third byte yields one to three results,
// emitted one per cycle by the back part while rsp_ready is high, so full rate holds with no stall.
// after the third byte's transfer, the first result passes the queue, the job reg and the output reg in turn.
// a two-entry job queue lets the front keep taking bytes while rsp is stalled;
// req_ready drops only on a third byte with the queue full.
// reset clears phase, counters, queue and output valid; csr_ready is always high.

module bmp24_to_rgb565_raster #(
   parameter int MAX_DIM = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_pixel_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_kind,
   output logic [9:0]                       rsp_cursor_x,
   output logic [10:0]                      rsp_cursor_y,
   output logic [15:0]                      rsp_color,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bmp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bmp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   bmp_pkg::cfg_type cfg_ff, cfg_in;
   bmp_pkg::job_type push_job, pop_job;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bmp_pkg::CSR_ORIGIN_X:     cfg_in.origin_x     = csr_wdata[9:0];
            bmp_pkg::CSR_ORIGIN_Y:     cfg_in.origin_y     = csr_wdata[9:0];
            bmp_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            bmp_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
            bmp_pkg::CSR_BOTTOM_UP:    cfg_in.bottom_up    = csr_wdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x     <= 10'd0;
         cfg_ff.origin_y     <= 10'd0;
         cfg_ff.image_width  <= 11'd1;
         cfg_ff.image_height <= 11'd1;
         cfg_ff.bottom_up    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmp_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_byte (req_pixel_byte),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_job       (push_job)
   );

   bmp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   bmp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_job      (pop_job),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_cursor_x (rsp_cursor_x),
      .rsp_cursor_y (rsp_cursor_y),
      .rsp_color    (rsp_color),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== hdl/bmp_front.sv =====
// bmp_front: byte assembly, raster counters and cursor line computation
// depends on bmp_pkg; pushes one job per completed pixel into the queue

module bmp_front #(
   parameter int MAX_DIM = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  bmp_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_pixel_byte,
   output logic             push_valid,
   input  logic             push_ready,
   output bmp_pkg::job_type push_job
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int AW = (((CW + 1) > 11) ? (CW + 1) : 11) + 1;
   localparam logic [AW-1:0] MAX_V = AW'(MAX_DIM);

   // byte phase codes
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    second_ff, second_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;

   logic [AW-1:0] eff_w, eff_h, col_next, row_next;
   logic          col_wrap, row_wrap, take;
   logic [10:0]   oy, h11, r11;

   // zero acts as one, oversize acts as the maximum
   function automatic logic [AW-1:0] eff_dim(input logic [10:0] v);
      logic [AW-1:0] ext;
      ext = AW'(v);
      if (v == 11'd0) begin
         eff_dim = AW'(1);
      end else if (ext > MAX_V) begin
         eff_dim = MAX_V;
      end else begin
         eff_dim = ext;
      end
   endfunction

   assign eff_w    = eff_dim(cfg.image_width);
   assign eff_h    = eff_dim(cfg.image_height);
   assign col_next = AW'(col_ff) + AW'(1);
   assign row_next = AW'(row_ff) + AW'(1);
   assign col_wrap = (col_next >= eff_w);
   assign row_wrap = (row_next >= eff_h);

   // line arithmetic wraps at 11 bits
   assign oy  = {1'b0, cfg.origin_y};
   assign h11 = eff_h[10:0];
   assign r11 = row_next[10:0];

   // only the third byte of a triple needs queue space
   assign req_ready  = (phase_ff != PH_THIRD) || push_ready;
   assign take       = req_valid && req_ready;
   assign push_valid = req_valid && (phase_ff == PH_THIRD);

   // job contents
   always_comb begin
      push_job.color     = {second_ff[7:3], first_ff[7:2], req_pixel_byte[7:3]};
      push_job.cursor_x  = cfg.origin_x;
      push_job.has_start = (col_ff == '0) && (row_ff == '0);
      push_job.start_y   = cfg.bottom_up ? (oy + h11 - 11'd1) : oy;
      push_job.has_next  = col_wrap && !row_wrap;
      push_job.next_y    = cfg.bottom_up ? (oy + h11 - 11'd1 - r11) : (oy + r11);
   end

   // phase and counter update
   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (take) begin
         unique case (phase_ff)
            PH_SECOND: begin
               second_in = req_pixel_byte;
               phase_in  = PH_THIRD;
            end
            PH_THIRD: begin
               phase_in = PH_FIRST;
               if (col_wrap) begin
                  col_in = '0;
                  row_in = row_wrap ? '0 : row_next[CW-1:0];
               end else begin
                  col_in = col_next[CW-1:0];
               end
            end
            default: begin
               first_in = req_pixel_byte;
               phase_in = PH_SECOND;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // held bytes
   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule

// ===== hdl/bmp_queue.sv =====
// bmp_queue: two-entry job queue between the front and back parts
// depends on bmp_pkg for the job type

module bmp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  bmp_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output bmp_pkg::job_type pop_job
);

   bmp_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/bmp_back.sv =====
// bmp_back: expands each job into cursor and pixel results, one per cycle while rsp is not stalled
// depends on bmp_pkg; drives the registered result channel

module bmp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  bmp_pkg::job_type pop_job,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [9:0]       rsp_cursor_x,
   output logic [10:0]      rsp_cursor_y,
   output logic [15:0]      rsp_color,
   output logic             rsp_last
);

   bmp_pkg::job_type job_ff, job_in;
   logic job_valid_ff, job_valid_in;
   logic pend_start_ff, pend_start_in;
   logic pend_pix_ff, pend_pix_in;
   logic pend_next_ff, pend_next_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [9:0]  cx_ff, cx_in;
   logic [10:0] cy_ff, cy_in;
   logic [15:0] color_ff, color_in;
   logic        last_ff, last_in;

   logic out_free, fire, fin;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = job_valid_ff && out_free;
   assign fin       = !pend_start_ff && (!pend_pix_ff || !pend_next_ff);
   assign pop_ready = !job_valid_ff || (fire && fin);

   // job register and pending results
   always_comb begin
      job_in        = job_ff;
      job_valid_in  = job_valid_ff;
      pend_start_in = pend_start_ff;
      pend_pix_in   = pend_pix_ff;
      pend_next_in  = pend_next_ff;
      if (fire) begin
         if (pend_start_ff) begin
            pend_start_in = 1'b0;
         end else if (pend_pix_ff) begin
            pend_pix_in = 1'b0;
         end else begin
            pend_next_in = 1'b0;
         end
         if (fin) begin
            job_valid_in = 1'b0;
         end
      end
      if (pop_valid && pop_ready) begin
         job_in        = pop_job;
         job_valid_in  = 1'b1;
         pend_start_in = pop_job.has_start;
         pend_pix_in   = 1'b1;
         pend_next_in  = pop_job.has_next;
      end
   end

   // next result selection
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      color_in     = color_ff;
      last_in      = last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (pend_start_ff) begin
            kind_in  = bmp_pkg::KIND_CURSOR;
            cx_in    = job_ff.cursor_x;
            cy_in    = job_ff.start_y;
            color_in = '0;
            last_in  = 1'b0;
         end else if (pend_pix_ff) begin
            kind_in  = bmp_pkg::KIND_PIXEL;
            cx_in    = '0;
            cy_in    = '0;
            color_in = job_ff.color;
            last_in  = !pend_next_ff;
         end else begin
            kind_in  = bmp_pkg::KIND_CURSOR;
            cx_in    = job_ff.cursor_x;
            cy_in    = job_ff.next_y;
            color_in = '0;
            last_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff  <= 1'b0;
         pend_start_ff <= 1'b0;
         pend_pix_ff   <= 1'b0;
         pend_next_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         job_valid_ff  <= job_valid_in;
         pend_start_ff <= pend_start_in;
         pend_pix_ff   <= pend_pix_in;
         pend_next_ff  <= pend_next_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      kind_ff  <= kind_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_cursor_x = cx_ff;
   assign rsp_cursor_y = cy_ff;
   assign rsp_color    = color_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== hdl/bmp_checker.sv =====
// bmp_checker: port-level assertions for bmp24_to_rgb565_raster
// depends on bmp_pkg; attached to the top level by the bind below

module bmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [9:0]  rsp_cursor_x,
   input logic [10:0] rsp_cursor_y,
   input logic [15:0] rsp_color,
   input logic        rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_color)
         && $stable(rsp_cursor_x) && $stable(rsp_cursor_y) && $stable(rsp_last))
      else $error("result changed while stalled");

   // pixel writes carry no cursor
   a_pixel_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == bmp_pkg::KIND_PIXEL) |-> (rsp_cursor_x == 10'd0)
         && (rsp_cursor_y == 11'd0))
      else $error("pixel write with nonzero cursor");

   // cursor commands carry no color
   a_cursor_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == bmp_pkg::KIND_CURSOR) |-> (rsp_color == 16'd0))
      else $error("cursor command with nonzero color");

   // a taken cursor that is not last may be followed only by a pixel or by no valid result
   a_cursor_then_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == bmp_pkg::KIND_CURSOR) && !rsp_last
         |=> !rsp_valid || (rsp_kind == bmp_pkg::KIND_PIXEL))
      else $error("origin cursor not followed by pixel");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bmp24_to_rgb565_raster bmp_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_kind     (rsp_kind),
   .rsp_cursor_x (rsp_cursor_x),
   .rsp_cursor_y (rsp_cursor_y),
   .rsp_color    (rsp_color),
   .rsp_last     (rsp_last)
);
